// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk_i with rst_ni as reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define CLT_ASSERT_NEVER(lbl, cond, msg) \
  `CLT_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Types and constants of the change log table.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  localparam int LogEntriesDef = 16;
  localparam int FlagCountDef  = 32768;

  localparam logic [14:0] IdLimit       = 15'h7FFF;
  localparam logic [15:0] EmptyId       = 16'hFFFF;
  localparam logic [7:0]  CountMax      = 8'hFF;
  localparam logic [31:0] TimeNone      = 32'hFFFF_FFFF;
  localparam logic [6:0]  ShowTimeReset = 7'd120;
  localparam logic [7:0]  BrightFloor   = 8'd32;
  localparam logic [7:0]  BrightFull    = 8'd255;

  typedef struct packed {
    logic        mode;
    logic [14:0] flag_id;
    logic [31:0] new_value;
    logic [31:0] current_value;
    logic [31:0] now_frame;
    logic [3:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic        logged;
    logic [3:0]  slot_written;
    logic        visible;
    logic [15:0] entry_id;
    logic [31:0] entry_value;
    logic [7:0]  brightness;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/change_log_table_oldest_replace_core.sv =====
// ----------------------------------------------------------------------------
// change_log_table_oldest_replace_core
// Recent-change trace table with per-flag change counters and replacement
// of the oldest entry.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. A change
// request logs a flag change; a read request returns one table slot with its
// visibility and brightness. Every request yields exactly one result, shown
// for one cycle with rsp_valid_o high; the receiver cannot hold it off.
// The show time register is written through cfg_we_i and cfg_wdata_i.
// The request cycle reads the counter and value memories, the next cycle
// checks, updates and answers. A change that must evict an entry walks all
// LOG_ENTRIES times, one per cycle, before it answers. busy drops in the cycle
// after the result, so a new request is taken only once the last result is out.
// After reset the counter memory is cleared one entry per cycle, which
// keeps busy high until every entry is cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module change_log_table_oldest_replace_core #(
  parameter int LOG_ENTRIES = clt_pkg::LogEntriesDef,
  parameter int FLAG_COUNT  = clt_pkg::FlagCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  clt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output clt_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i
);

  import clt_pkg::*;

  localparam int IW  = $clog2(LOG_ENTRIES);
  localparam int CAW = $clog2(FLAG_COUNT);

  state_e         state_q, state_d;
  req_t           req_q, req_d;
  logic [CAW-1:0] clr_q, clr_d;
  logic [IW-1:0]  scan_q, scan_d;
  logic [IW-1:0]  best_idx_q, best_idx_d;
  logic [31:0]    best_time_q, best_time_d;
  logic [6:0]     show_time_q;

  logic           cnt_we;
  logic [CAW-1:0] cnt_waddr;
  logic [7:0]     cnt_wdata;
  logic [7:0]     cnt_rdata;

  logic           tbl_we;
  logic [IW-1:0]  tbl_waddr;
  logic [IW-1:0]  tbl_sel;
  logic [IW-1:0]  look_idx;
  logic [IW-1:0]  in_idx;
  logic [IW+3:0]  look_ext;
  logic [IW+3:0]  in_ext;
  logic [15:0]    sel_id;
  logic [31:0]    sel_time;
  logic [31:0]    rd_value;
  logic           hit;
  logic [IW-1:0]  hit_idx;

  logic           out_of_range;
  logic           drop;
  logic [31:0]    age;
  logic           vis;
  logic [7:0]     bright;
  rsp_t           read_rsp;

  assign look_ext = {{IW{1'b0}}, req_q.slot_index};
  assign look_idx = look_ext[IW-1:0];
  assign in_ext   = {{IW{1'b0}}, req_i.slot_index};
  assign in_idx   = in_ext[IW-1:0];
  assign tbl_sel  = (state_q == ST_SCAN) ? scan_q : look_idx;

  clt_count_mem #(
    .FLAG_COUNT(FLAG_COUNT)
  ) u_count_mem (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(req_i.flag_id[CAW-1:0]),
    .rdata_o(cnt_rdata)
  );

  clt_entry_table #(
    .LOG_ENTRIES(LOG_ENTRIES)
  ) u_entry_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (in_idx),
    .rd_value_o(rd_value),
    .sel_i     (tbl_sel),
    .sel_id_o  (sel_id),
    .sel_time_o(sel_time),
    .key_i     (req_q.flag_id),
    .hit_o     (hit),
    .hit_idx_o (hit_idx),
    .we_i      (tbl_we),
    .waddr_i   (tbl_waddr),
    .wid_i     (req_q.flag_id),
    .wvalue_i  (req_q.new_value),
    .wtime_i   (req_q.now_frame)
  );

  assign out_of_range = int'(req_q.slot_index) >= LOG_ENTRIES;
  assign drop = (req_q.new_value == req_q.current_value) ||
                (req_q.flag_id >= IdLimit) ||
                (int'(req_q.flag_id) >= FLAG_COUNT) ||
                (cnt_rdata == CountMax);

  assign age = req_q.now_frame - sel_time;
  assign vis = !out_of_range && (sel_id != EmptyId) && (age < {25'b0, show_time_q});

  always_comb begin
    bright = BrightFull - {age[6:0], 1'b0};
    if (bright < BrightFloor) begin
      bright = BrightFloor;
    end
    read_rsp              = '0;
    read_rsp.visible      = vis;
    read_rsp.entry_id     = out_of_range ? EmptyId : sel_id;
    read_rsp.entry_value  = out_of_range ? 32'd0 : rd_value;
    read_rsp.brightness   = vis ? bright : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      show_time_q <= ShowTimeReset;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        show_time_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    scan_q      <= scan_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
  end

  always_comb begin
    logic          take;
    logic [IW-1:0] pick;
    logic [IW+3:0] slot_ext;

    state_d     = state_q;
    req_d       = req_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    cnt_we      = 1'b0;
    cnt_waddr   = req_q.flag_id[CAW-1:0];
    cnt_wdata   = cnt_rdata + 8'd1;
    tbl_we      = 1'b0;
    tbl_waddr   = hit_idx;
    rsp_valid_o = 1'b0;
    rsp_o       = '0;
    take        = (scan_q == '0) || (sel_time < best_time_q);
    pick        = take ? scan_q : best_idx_q;
    slot_ext    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        if (clr_q == CAW'(FLAG_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (req_q.mode) begin
          rsp_valid_o = 1'b1;
          rsp_o       = read_rsp;
          state_d     = ST_IDLE;
        end else if (drop) begin
          rsp_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cnt_we = 1'b1;
          if (hit) begin
            tbl_we             = 1'b1;
            tbl_waddr          = hit_idx;
            slot_ext           = {4'b0, hit_idx};
            rsp_valid_o        = 1'b1;
            rsp_o.logged       = 1'b1;
            rsp_o.slot_written = slot_ext[3:0];
            state_d            = ST_IDLE;
          end else begin
            scan_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_idx_d  = scan_q;
          best_time_d = sel_time;
        end
        if (scan_q == IW'(LOG_ENTRIES - 1)) begin
          tbl_we             = 1'b1;
          tbl_waddr          = pick;
          slot_ext           = {4'b0, pick};
          rsp_valid_o        = 1'b1;
          rsp_o.logged       = 1'b1;
          rsp_o.slot_written = slot_ext[3:0];
          state_d            = ST_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  `CLT_ASSERT(a_accept_to_look, (start && !busy) |=> (state_q == ST_LOOK), "accepted request did not enter lookup")
  `CLT_ASSERT(a_single_result, rsp_valid_o |=> !rsp_valid_o, "two results in a row")
  `CLT_ASSERT_NEVER(a_result_idle, rsp_valid_o && !busy, "result while idle")
  `CLT_ASSERT(a_scan_holds_req, (state_q == ST_SCAN) |-> $stable(req_q), "request changed during scan")

endmodule

`default_nettype wire

// ===== rtl/clt_count_mem.sv =====
// ----------------------------------------------------------------------------
// clt_count_mem
// Per-flag change counter store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_count_mem #(
  parameter int FLAG_COUNT = clt_pkg::FlagCountDef,
  localparam int AW = $clog2(FLAG_COUNT)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [FLAG_COUNT];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/clt_entry_table.sv =====
// ----------------------------------------------------------------------------
// clt_entry_table
// Trace entries: ids and times in registers with a parallel id search, values
// in a small memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_entry_table #(
  parameter int LOG_ENTRIES = clt_pkg::LogEntriesDef,
  localparam int IW = $clog2(LOG_ENTRIES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [IW-1:0] rd_addr_i,
  output logic [31:0]   rd_value_o,
  input  logic [IW-1:0] sel_i,
  output logic [15:0]   sel_id_o,
  output logic [31:0]   sel_time_o,
  input  logic [14:0]   key_i,
  output logic          hit_o,
  output logic [IW-1:0] hit_idx_o,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [14:0]   wid_i,
  input  logic [31:0]   wvalue_i,
  input  logic [31:0]   wtime_i
);

  import clt_pkg::*;

  logic [15:0] ids_q   [LOG_ENTRIES];
  logic [31:0] times_q [LOG_ENTRIES];
  logic [31:0] values  [LOG_ENTRIES];
  logic [31:0] rd_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOG_ENTRIES; i++) begin
        ids_q[i]   <= EmptyId;
        times_q[i] <= TimeNone;
      end
    end else if (we_i) begin
      ids_q[waddr_i]   <= {1'b0, wid_i};
      times_q[waddr_i] <= wtime_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      values[waddr_i] <= wvalue_i;
    end
    rd_value_q <= values[rd_addr_i];
  end

  // The lowest entry that holds the key or is empty wins.
  always_comb begin
    hit_o     = 1'b0;
    hit_idx_o = '0;
    for (int i = LOG_ENTRIES - 1; i >= 0; i--) begin
      if (ids_q[i] == {1'b0, key_i} || ids_q[i] == EmptyId) begin
        hit_o     = 1'b1;
        hit_idx_o = IW'(i);
      end
    end
  end

  assign rd_value_o = rd_value_q;
  assign sel_id_o   = ids_q[sel_i];
  assign sel_time_o = times_q[sel_i];

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the change log table with oldest-entry replacement.
// ----------------------------------------------------------------------------
// A directed opening covers dropped changes, filling the table, rewriting an
// existing id, replacing the oldest entry, wrapped ages and the brightness
// floor. Random requests follow: reads of any slot, changes to a hot flag
// until its counter saturates, a pool of ids that forces replacement, and
// frame jumps across the counter wrap. The show time is rewritten between
// phases while the block is idle. Every result is checked field by field
// against a table kept alongside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import clt_pkg::*;

  localparam int LogEntries   = LogEntriesDef;
  localparam int FlagCount    = FlagCountDef;
  localparam int PhaseCount   = 6;
  localparam int PhaseReqs    = 325;
  localparam int QuietLimit   = 100000;
  localparam int ShownFaults  = 10;
  localparam logic [14:0] HotFlag = 15'd5;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  req_t       req         = '0;
  logic       rsp_valid_o;
  rsp_t       rsp;
  logic       cfg_we_i    = 1'b0;
  logic [6:0] cfg_wdata_i = '0;

  logic [15:0] tbl_ids     [LogEntries];
  logic [31:0] tbl_values  [LogEntries];
  logic [31:0] tbl_times   [LogEntries];
  logic [7:0]  flag_counts [FlagCount];
  logic [6:0]  show_frames;

  req_t        trace_reqs[$];
  rsp_t        trace_rsps[$];
  logic [31:0] frame;
  int unsigned sender_idle_pct = 27;
  int unsigned fault_count     = 0;
  int unsigned quiet_cycles    = 0;

  change_log_table_oldest_replace_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic rsp_t trace_table_answer(req_t r);
    rsp_t        a;
    int unsigned slot;
    logic        found;
    logic [31:0] oldest;
    logic [31:0] age;
    logic [31:0] level;
    a = '0;
    if (r.mode == 1'b0) begin
      if (r.new_value != r.current_value && r.flag_id < IdLimit &&
          flag_counts[r.flag_id] != CountMax) begin
        flag_counts[r.flag_id] = flag_counts[r.flag_id] + 8'd1;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < LogEntries; i++) begin
          if (!found && (tbl_ids[i] == {1'b0, r.flag_id} || tbl_ids[i] == EmptyId)) begin
            slot  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          oldest = tbl_times[0];
          for (int i = 1; i < LogEntries; i++) begin
            if (tbl_times[i] < oldest) begin
              oldest = tbl_times[i];
              slot   = i;
            end
          end
        end
        tbl_ids[slot]    = {1'b0, r.flag_id};
        tbl_values[slot] = r.new_value;
        tbl_times[slot]  = r.now_frame;
        a.logged         = 1'b1;
        a.slot_written   = slot[3:0];
      end
    end else begin
      a.entry_id    = tbl_ids[r.slot_index];
      a.entry_value = tbl_values[r.slot_index];
      age = r.now_frame - tbl_times[r.slot_index];
      if (tbl_ids[r.slot_index] != EmptyId && age < {25'd0, show_frames}) begin
        level = {24'd0, BrightFull} - age * 32'd2;
        if (level < {24'd0, BrightFloor}) begin
          level = {24'd0, BrightFloor};
        end
        a.visible    = 1'b1;
        a.brightness = level[7:0];
      end
    end
    return a;
  endfunction

  function automatic req_t random_trace_req();
    req_t        r;
    int unsigned pick;
    r.mode          = 1'b0;
    r.flag_id       = 15'($urandom);
    r.new_value     = $urandom;
    r.current_value = $urandom;
    r.now_frame     = $urandom;
    r.slot_index    = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.mode = 1'b1;
      if ($urandom_range(19) != 0) begin
        r.now_frame = frame + $urandom_range(140);
      end
    end else begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        r.flag_id = HotFlag;
      end else if (pick < 80) begin
        r.flag_id = 15'(1000 + $urandom_range(39));
      end else if (pick >= 95) begin
        r.flag_id = IdLimit;
      end
      if ($urandom_range(32) == 0) begin
        frame = $urandom_range(1) ? $urandom : 32'hFFFF_FF80 + $urandom_range(127);
      end else begin
        frame = frame + $urandom_range(3);
      end
      r.now_frame = frame;
      if ($urandom_range(9) == 0) begin
        r.current_value = r.new_value;
      end
    end
    return r;
  endfunction

  task automatic push_req(input logic mode, input logic [14:0] id, input logic [31:0] nval,
                          input logic [31:0] cval, input logic [31:0] now,
                          input logic [3:0] slot);
    req_t r;
    r.mode          = mode;
    r.flag_id       = id;
    r.new_value     = nval;
    r.current_value = cval;
    r.now_frame     = now;
    r.slot_index    = slot;
    trace_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (trace_reqs.size() != 0 || trace_rsps.size() != 0 || start || busy) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        trace_rsps.push_back(trace_table_answer(req));
      end
      if (!start || !busy) begin
        if (trace_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          req   <= trace_reqs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (trace_rsps.size() == 0) begin
        fault_count++;
        if (fault_count <= ShownFaults) begin
          $display("unexpected result: %p", rsp);
        end
      end else begin
        want = trace_rsps.pop_front();
        if (rsp.logged !== want.logged || rsp.slot_written !== want.slot_written ||
            rsp.visible !== want.visible || rsp.entry_id !== want.entry_id ||
            rsp.entry_value !== want.entry_value || rsp.brightness !== want.brightness) begin
          fault_count++;
          if (fault_count <= ShownFaults) begin
            $display("result mismatch: expected %p", want);
            $display("                 actual   %p", rsp);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || rsp_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [6:0] show_settings [PhaseCount];
    show_settings = '{ShowTimeReset, 7'd127, 7'd1, 7'd0, 7'($urandom_range(2, 126)), 7'd113};
    for (int i = 0; i < LogEntries; i++) begin
      tbl_ids[i]    = EmptyId;
      tbl_values[i] = '0;
      tbl_times[i]  = TimeNone;
    end
    for (int i = 0; i < FlagCount; i++) begin
      flag_counts[i] = '0;
    end
    show_frames = ShowTimeReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PhaseCount; p++) begin
      if (p != 0) begin
        wait_drained();
        @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= show_settings[p];
        show_frames  = show_settings[p];
        @(posedge clk_i);
        cfg_we_i    <= 1'b0;
        @(negedge clk_i);
      end
      sender_idle_pct = (p < 2) ? 27 : (p < 4) ? 73 : 0;
      if (p == 0) begin
        push_req(1'b0, 15'd0, 32'd0, 32'd0, 32'd0, 4'd0);
        push_req(1'b0, IdLimit, 32'd1, 32'd0, 32'd0, 4'd0);
        push_req(1'b0, 15'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 4'd0);
        push_req(1'b1, 15'd0, 32'd0, 32'd0, 32'd0, 4'd0);
        push_req(1'b0, 15'h7FFE, 32'd0, 32'hFFFF_FFFF, 32'd1, 4'd0);
        push_req(1'b0, 15'd0, 32'd5, 32'hFFFF_FFFF, 32'd2, 4'd0);
        push_req(1'b1, IdLimit, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1);
        for (int k = 0; k < LogEntries - 2; k++) begin
          push_req(1'b0, 15'(100 + k), 32'(k + 1), 32'd0, 32'd10, 4'd0);
        end
        push_req(1'b0, 15'd200, 32'hA5A5_A5A5, 32'd1, 32'd20, 4'd0);
        push_req(1'b1, 15'd0, 32'd0, 32'd0, 32'd121, 4'd15);
        push_req(1'b1, 15'd0, 32'd0, 32'd0, 32'd125, 4'd2);
        push_req(1'b1, 15'd0, 32'd0, 32'd0, 32'd130, 4'd3);
        frame = 32'd130;
      end
      while (trace_reqs.size() < PhaseReqs) begin
        trace_reqs.push_back(random_trace_req());
      end
    end

    wait_drained();
    repeat (LogEntries + 4) @(posedge clk_i);
    fault_count += trace_rsps.size();
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
